@@ hdl/gpc_pkg.sv @@
// shared types and constants for the geometric mass / cumulative unit
package gpc_pkg;

  localparam int K_W      = 32;
  localparam int P_W      = 33;
  localparam int VALUE_W  = 33;
  localparam int EXP_BITS = K_W - 1;

  typedef enum logic {
    REQ_MASS = 1'b0,
    REQ_CUMULATIVE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                  req_type;
    logic signed [K_W-1:0] k;
    logic [P_W-1:0]        p;
  } gpc_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } gpc_rsp_t;

  typedef struct packed {
    logic req_type;
    logic invalid;
    logic zero;
    logic acc_one;
    logic p_one;
  } gpc_ctl_t;

endpackage

@@ hdl/gpc_prep.sv @@
// input stage: checks p and k, forms q and the exponent
module gpc_prep import gpc_pkg::*; #(
  parameter int FB = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  input  gpc_req_t            up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output gpc_ctl_t            dn_ctl,
  output logic [FB:0]         dn_p,
  output logic [FB-1:0]       dn_base,
  output logic [EXP_BITS-1:0] dn_exp,
  input  logic                dn_ready
);

  localparam int WW = (FB + 1 > P_W) ? FB + 1 : P_W;
  localparam logic [WW-1:0] ONE_W = WW'(1) << FB;
  localparam logic [FB:0]   ONE   = (FB + 1)'(1) << FB;

  logic [WW-1:0]       p_wide;
  logic [FB:0]         p_int;
  logic [FB:0]         q_full;
  logic                p_bad;
  logic                k_pos;
  logic [EXP_BITS-1:0] exp_next;
  gpc_ctl_t            ctl_next;

  always_comb begin
    p_wide = WW'(up_data.p);
    p_bad  = (p_wide == '0) || (p_wide > ONE_W);
    p_int  = p_wide[FB:0];
    q_full = ONE - p_int;
    k_pos  = (up_data.k != '0) && !up_data.k[K_W-1];
    if (up_data.req_type == REQ_CUMULATIVE) begin
      exp_next = up_data.k[EXP_BITS-1:0];
    end else begin
      exp_next = up_data.k[EXP_BITS-1:0] - EXP_BITS'(1);
    end
    ctl_next.req_type = up_data.req_type;
    ctl_next.invalid  = p_bad;
    ctl_next.zero     = !k_pos;
    ctl_next.acc_one  = 1'b1;
    ctl_next.p_one    = (p_int == ONE);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_ctl  <= ctl_next;
      dn_p    <= p_int;
      dn_base <= q_full[FB-1:0];
      dn_exp  <= exp_next;
    end
  end

endmodule

@@ hdl/gpc_cell.sv @@
// one square-and-multiply cell: consumes one exponent bit
module gpc_cell import gpc_pkg::*; #(
  parameter int FB = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  input  gpc_ctl_t            up_ctl,
  input  logic [FB:0]         up_p,
  input  logic [FB-1:0]       up_acc,
  input  logic [FB-1:0]       up_base,
  input  logic [EXP_BITS-1:0] up_exp,
  output logic                up_ready,
  output logic                dn_valid,
  output gpc_ctl_t            dn_ctl,
  output logic [FB:0]         dn_p,
  output logic [FB-1:0]       dn_acc,
  output logic [FB-1:0]       dn_base,
  output logic [EXP_BITS-1:0] dn_exp,
  input  logic                dn_ready
);

  logic [2*FB-1:0] acc_prod;
  logic [2*FB-1:0] sq_prod;
  logic [FB-1:0]   acc_next;
  gpc_ctl_t        ctl_next;

  always_comb begin
    acc_prod = {{FB{1'b0}}, up_acc} * {{FB{1'b0}}, up_base};
    sq_prod  = {{FB{1'b0}}, up_base} * {{FB{1'b0}}, up_base};
    ctl_next = up_ctl;
    acc_next = up_acc;
    if (up_exp[0]) begin
      // an accumulator still at one just takes the base
      acc_next         = up_ctl.acc_one ? up_base : acc_prod[2*FB-1:FB];
      ctl_next.acc_one = 1'b0;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_ctl  <= ctl_next;
      dn_p    <= up_p;
      dn_acc  <= acc_next;
      dn_base <= sq_prod[2*FB-1:FB];
      dn_exp  <= up_exp >> 1;
    end
  end

endmodule

@@ hdl/gpc_final.sv @@
// output stage: mass or cumulative result, held in the output register
module gpc_final import gpc_pkg::*; #(
  parameter int FB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  gpc_ctl_t      up_ctl,
  input  logic [FB:0]   up_p,
  input  logic [FB-1:0] up_acc,
  output logic          up_ready,
  output logic          dn_valid,
  output gpc_rsp_t      dn_data,
  input  logic          dn_stall
);

  localparam int WW = (FB + 1 > VALUE_W) ? FB + 1 : VALUE_W;
  localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

  logic [2*FB-1:0] mass_prod;
  logic [FB:0]     acc_full;
  logic [FB:0]     result;
  logic [WW-1:0]   result_wide;
  gpc_rsp_t        rsp_next;

  always_comb begin
    mass_prod = {{FB{1'b0}}, up_p[FB-1:0]} * {{FB{1'b0}}, up_acc};
    acc_full  = up_ctl.acc_one ? ONE : {1'b0, up_acc};
    if (up_ctl.req_type == REQ_CUMULATIVE) begin
      result = ONE - acc_full;
    end else if (up_ctl.acc_one) begin
      result = up_p;
    end else if (up_ctl.p_one) begin
      result = acc_full;
    end else begin
      result = {1'b0, mass_prod[2*FB-1:FB]};
    end
    if (up_ctl.invalid || up_ctl.zero) begin
      result = '0;
    end
    result_wide     = WW'(result);
    rsp_next.value  = result_wide[VALUE_W-1:0];
    rsp_next.status = up_ctl.invalid;
  end

  assign up_ready = !dn_valid || !dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= rsp_next;
    end
  end

endmodule

@@ hdl/geometric_pmf_cdf_unit.sv @@
// a request passes the input stage, one cell per exponent bit and the output stage, each registered
// throughput: one request per cycle while rsp_stall is low; each stage holds one request in flight
// the rate is set by one cell per exponent bit, each with its own two multipliers
// a stage takes a new request whenever it is empty or its neighbor moves on
// reset: synchronous, active high, clears every stage valid bit; payload is not reset
module geometric_pmf_cdf_unit import gpc_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  gpc_req_t req_data,
  output logic     req_stall,
  output logic     rsp_valid,
  output gpc_rsp_t rsp_data,
  input  logic     rsp_stall
);

  // stage 0 is the input stage, stage i+1 is the output of cell i
  logic                valid_c [0:EXP_BITS];
  logic                ready_c [0:EXP_BITS];
  gpc_ctl_t            ctl_c   [0:EXP_BITS];
  logic [FRAC_BITS:0]  p_c     [0:EXP_BITS];
  logic [FRAC_BITS-1:0] acc_c  [0:EXP_BITS];
  logic [FRAC_BITS-1:0] base_c [0:EXP_BITS];
  logic [EXP_BITS-1:0] exp_c   [0:EXP_BITS];
  logic                prep_ready;

  // check p and k, form q = 1 - p and the exponent (k or k - 1)
  gpc_prep #(.FB(FRAC_BITS)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_data  (req_data),
    .up_ready (prep_ready),
    .dn_valid (valid_c[0]),
    .dn_ctl   (ctl_c[0]),
    .dn_p     (p_c[0]),
    .dn_base  (base_c[0]),
    .dn_exp   (exp_c[0]),
    .dn_ready (ready_c[0])
  );

  assign req_stall = !prep_ready;

  // accumulator starts at one, tracked by a flag rather than stored
  assign acc_c[0] = '0;

  // chain of cells, least significant exponent bit first
  for (genvar i = 0; i < EXP_BITS; i++) begin : g_cell
    gpc_cell #(.FB(FRAC_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid_c[i]),
      .up_ctl   (ctl_c[i]),
      .up_p     (p_c[i]),
      .up_acc   (acc_c[i]),
      .up_base  (base_c[i]),
      .up_exp   (exp_c[i]),
      .up_ready (ready_c[i]),
      .dn_valid (valid_c[i+1]),
      .dn_ctl   (ctl_c[i+1]),
      .dn_p     (p_c[i+1]),
      .dn_acc   (acc_c[i+1]),
      .dn_base  (base_c[i+1]),
      .dn_exp   (exp_c[i+1]),
      .dn_ready (ready_c[i+1])
    );
  end

  // mass = p * q^(k-1), cumulative = 1 - q^k, zero or invalid overrides
  gpc_final #(.FB(FRAC_BITS)) u_final (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid_c[EXP_BITS]),
    .up_ctl   (ctl_c[EXP_BITS]),
    .up_p     (p_c[EXP_BITS]),
    .up_acc   (acc_c[EXP_BITS]),
    .up_ready (ready_c[EXP_BITS]),
    .dn_valid (rsp_valid),
    .dn_data  (rsp_data),
    .dn_stall (rsp_stall)
  );

endmodule
